@@ rtl/core/gbba_pkg.sv @@
`timescale 1ns / 1ps
package gbba_pkg;
   localparam int MAP_DEPTH = 2048;
   localparam int MAP_AW = 11;
   localparam int GRP_DEPTH = 64;
   localparam int GRP_AW = 6;

   localparam logic [1:0] CMD_CLAIM = 2'd0;
   localparam logic [1:0] CMD_MARK = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;
   localparam logic [1:0] CMD_LOAD = 2'd3;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_USED = 3'd2;
   localparam logic [2:0] ST_ZERO = 3'd3;
   localparam logic [2:0] ST_RANGE = 3'd4;

   localparam logic [1:0] REG_FIRST = 2'd0;
   localparam logic [1:0] REG_GSIZE = 2'd1;
   localparam logic [1:0] REG_TOTAL = 2'd2;
   localparam logic [1:0] REG_GCOUNT = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DIV, S_SETUP, S_GROUP, S_RD, S_CHK, S_ONE, S_ONECHK,
      S_DONE
   } state_type;

   // lowest set bit of a 32-bit word
   function automatic logic [4:0] low_one(input logic [31:0] w);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 31; i >= 0; i--) begin
         if (w[i]) r = 5'(i);
      end
      return r;
   endfunction
endpackage

@@ rtl/core/gbba_ram.sv @@
`timescale 1ns / 1ps
module gbba_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ rtl/core/grouped_bitmap_block_allocator.sv @@
`timescale 1ns / 1ps
// Load and a zero layout are answered from idle. Mark/release run a divide, a range check
// and, when in range, one bitmap word read and update. Claim runs the divide, then a group
// modulo divide when the hint is at or above first_block, then bitmap word reads per group.
// Throughput: one word at a time; the next is taken the cycle after the result leaves.
// Reset: synchronous; a clearing pass zeroes bitmap and counters, no word accepted
// meanwhile. Configuration returns to its reset values.
module grouped_bitmap_block_allocator
   import gbba_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_hint_block,
   input  logic [15:0] req_target_block,
   input  logic [5:0]  req_group_index,
   input  logic [15:0] req_count_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_block_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [16:0] csr_data
);
   logic        first_ff;
   logic [16:0] gsize_ff, total_ff;
   logic [6:0]  gcount_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1; gsize_ff <= 17'd8192; total_ff <= 17'd65536;
         gcount_ff <= 7'd8;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_FIRST:  first_ff <= csr_data[0];
            REG_GSIZE:  gsize_ff <= csr_data;
            REG_TOTAL:  total_ff <= csr_data;
            REG_GCOUNT: gcount_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;

   logic [6:0]  ng;
   logic [16:0] lim;
   assign ng = (gcount_ff > 7'(GRP_DEPTH)) ? 7'(GRP_DEPTH) : gcount_ff;
   assign lim = (total_ff > 17'(MAP_DEPTH * 32)) ? 17'(MAP_DEPTH * 32) : total_ff;

   state_type state_ff, state_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic [16:0] rel_ff, rel_in;     // block - first_block
   logic        below_ff, below_in; // block below first_block
   logic        mod_ff, mod_in;     // second divide pass: quotient mod group count
   logic [16:0] quo_ff, quo_in, rem_ff, rem_in;
   logic [4:0]  dcnt_ff, dcnt_in;
   logic [6:0]  grp_ff, grp_in, gi_ff, gi_in;
   logic [16:0] pos_ff, pos_in, endr_ff, endr_in;
   logic [11:0] clr_ff, clr_in;
   logic        rv_ff, rv_in;
   logic [2:0]  st_ff, st_in;
   logic [15:0] bo_ff, bo_in;

   logic            map_we, cnt_we;
   logic [MAP_AW-1:0] map_wa, map_ra;
   logic [31:0]     map_wd, map_rd;
   logic [GRP_AW-1:0] cnt_wa, cnt_ra;
   logic [15:0]     cnt_wd, cnt_rd;

   gbba_ram #(.WIDTH(32), .DEPTH(MAP_DEPTH)) u_map (
      .clock, .wr_en(map_we), .wr_addr(map_wa), .wr_data(map_wd),
      .rd_addr(map_ra), .rd_data(map_rd));
   gbba_ram #(.WIDTH(16), .DEPTH(GRP_DEPTH)) u_cnt (
      .clock, .wr_en(cnt_we), .wr_addr(cnt_wa), .wr_data(cnt_wd),
      .rd_addr(cnt_ra), .rd_data(cnt_rd));

   logic [16:0] dvsr;
   logic [17:0] trial;
   logic [23:0] gprod;
   logic [31:0] mask, freew, bitm;
   logic [4:0]  lo, hi_ix;
   logic [16:0] ndx;
   logic [16:0] found;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; rv_ff <= rv_in;
      end
      cmd_ff <= cmd_in; rel_ff <= rel_in; below_ff <= below_in; mod_ff <= mod_in;
      quo_ff <= quo_in; rem_ff <= rem_in; dcnt_ff <= dcnt_in;
      grp_ff <= grp_in; gi_ff <= gi_in; pos_ff <= pos_in;
      endr_ff <= endr_in; st_ff <= st_in; bo_ff <= bo_in;
   end

   always_comb begin
      state_in = state_ff; cmd_in = cmd_ff; rel_in = rel_ff; below_in = below_ff;
      mod_in = mod_ff; quo_in = quo_ff; rem_in = rem_ff;
      dcnt_in = dcnt_ff; grp_in = grp_ff; gi_in = gi_ff;
      pos_in = pos_ff; endr_in = endr_ff; clr_in = clr_ff; rv_in = rv_ff;
      st_in = st_ff; bo_in = bo_ff;
      map_we = 1'b0; map_wa = pos_ff[15:5]; map_wd = '0; map_ra = pos_ff[15:5];
      cnt_we = 1'b0; cnt_wa = grp_ff[5:0]; cnt_wd = '0; cnt_ra = grp_ff[5:0];
      req_stall = 1'b1;
      dvsr = mod_ff ? 17'(ng) : gsize_ff;
      trial = {rem_ff, quo_ff[16]} - {1'b0, dvsr};
      gprod = 24'(grp_ff) * 24'(gsize_ff);
      lo = pos_ff[4:0];
      hi_ix = (endr_ff - 17'd1 - {pos_ff[16:5], 5'd0}) > 17'd31 ? 5'd31
            : 5'(endr_ff - 17'd1 - {pos_ff[16:5], 5'd0});
      mask = ({32{1'b1}} << lo) & ({32{1'b1}} >> (5'd31 - hi_ix));
      freew = ~map_rd & mask;
      found = {pos_ff[16:5], low_one(freew)};
      bitm = 32'd1 << pos_ff[4:0];
      ndx = {pos_ff[16:5], 5'd0} + 17'd32;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            map_we = 1'b1; map_wa = clr_ff[10:0];
            cnt_we = 1'b1; cnt_wa = clr_ff[5:0];
            clr_in = clr_ff + 12'd1;
            if (clr_ff == 12'd2047) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_stall = rv_ff;
            if (req_valid && !rv_ff) begin
               cmd_in = req_cmd; mod_in = 1'b0;
               rel_in = (req_cmd == CMD_CLAIM) ? 17'(req_hint_block) - 17'(first_ff)
                                               : 17'(req_target_block) - 17'(first_ff);
               below_in = (req_cmd == CMD_CLAIM) ? (req_hint_block < 16'(first_ff))
                                                 : (req_target_block < 16'(first_ff));
               quo_in = (req_cmd == CMD_CLAIM) ? 17'(req_hint_block) - 17'(first_ff)
                                               : 17'(req_target_block) - 17'(first_ff);
               rem_in = '0; dcnt_in = '0; bo_in = '0; st_in = ST_OK;
               if (req_cmd == CMD_LOAD) begin
                  cnt_we = 1'b1; cnt_wa = req_group_index; cnt_wd = req_count_value;
                  rv_in = 1'b1;
               end else if (gsize_ff == 17'd0 || ng == 7'd0) begin
                  st_in = (req_cmd == CMD_CLAIM) ? ST_FULL : ST_RANGE;
                  rv_in = 1'b1;
               end else state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (!trial[17]) begin
               rem_in = trial[16:0]; quo_in = {quo_ff[15:0], 1'b1};
            end else begin
               rem_in = {rem_ff[15:0], quo_ff[16]}; quo_in = {quo_ff[15:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 5'd1;
            if (dcnt_ff == 5'd16) begin
               if (!mod_ff && cmd_ff == CMD_CLAIM && !below_ff) begin
                  mod_in = 1'b1; dcnt_in = '0; rem_in = '0;
               end else state_in = S_SETUP;
            end
         end
         S_SETUP: begin
            gi_in = '0;
            if (cmd_ff == CMD_CLAIM) begin
               grp_in = below_ff ? 7'd0 : rem_ff[6:0];
               state_in = S_GROUP;
            end else begin
               if (below_ff || 17'(rel_ff) + 17'(first_ff) >= lim || quo_ff >= 17'(ng)
                   || rel_ff[16]) begin
                  st_in = ST_RANGE; rv_in = 1'b1; state_in = S_IDLE;
               end else begin
                  grp_in = 7'(quo_ff); pos_in = rel_ff; state_in = S_ONE;
               end
            end
         end
         S_GROUP: begin
            state_in = S_RD;
            if (gprod + 24'(first_ff) >= 24'(lim) || gi_ff >= ng) begin
               st_in = ST_FULL; rv_in = 1'b1; state_in = S_IDLE;
            end else begin
               pos_in = gprod[16:0];
               endr_in = (gprod + 24'(gsize_ff) + 24'(first_ff) > 24'(lim))
                         ? lim - 17'(first_ff) : 17'(gprod + 24'(gsize_ff));
            end
         end
         S_RD: begin
            state_in = S_CHK;
         end
         S_CHK: begin
            if (freew != 32'd0) begin
               if (cnt_rd == 16'd0) begin
                  st_in = ST_ZERO;
               end else begin
                  map_we = 1'b1; map_wd = map_rd | (32'd1 << low_one(freew));
                  cnt_we = 1'b1; cnt_wd = cnt_rd - 16'd1;
                  bo_in = 16'(found + 17'(first_ff));
               end
               rv_in = 1'b1; state_in = S_IDLE;
            end else if (ndx >= endr_ff) begin
               gi_in = gi_ff + 7'd1;
               grp_in = (grp_ff + 7'd1 >= ng) ? 7'd0 : grp_ff + 7'd1;
               state_in = S_GROUP;
            end else begin
               pos_in = ndx; state_in = S_RD;
            end
         end
         S_ONE: state_in = S_ONECHK;
         S_ONECHK: begin
            if (cmd_ff == CMD_MARK) begin
               if ((map_rd & bitm) != 32'd0) st_in = ST_USED;
               else begin
                  map_we = 1'b1; map_wd = map_rd | bitm;
               end
            end else begin
               map_we = 1'b1; map_wd = map_rd & ~bitm;
               cnt_we = 1'b1; cnt_wd = cnt_rd + 16'd1;
            end
            rv_in = 1'b1; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_block_out = bo_ff;

   a_stall_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("accepted during clear");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("accept while result pending");
   a_zero_blk: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != ST_OK) |-> rsp_block_out == 16'd0)
      else $error("block on failure");
endmodule
